@@ rtl/mmcs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and the class lookup for the memory-map sorter.
// Used by every module under rtl/.
package mmcs_pkg;

	localparam int MAX_REGIONS_DEF = 64;

	localparam int ADDR_W  = 64;
	localparam int TYPE_W  = 32;
	localparam int KIND_W  = 3;
	localparam int CLASS_W = 2;
	localparam int STAT_W  = 2;

	localparam int IN_DATA_W  = 160;  // start, len, source type
	localparam int OUT_DATA_W = 192;  // start, end, len
	localparam int OUT_USER_W = 7;    // class, sub-kind, status

	localparam logic [TYPE_W-1:0] TYPE_FIRST = 32'd1;
	localparam logic [TYPE_W-1:0] TYPE_LAST  = 32'd6;

	localparam logic [KIND_W-1:0] KIND_USABLE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RESERVE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ACPI_RC = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ACPI_NV = 3'd3;

	localparam logic [CLASS_W-1:0] CLASS_RAM      = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_RESERVED = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_ACPI     = 2'd2;
	localparam logic [CLASS_W-1:0] CLASS_DEFECT   = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_TYPE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] len;
		logic [KIND_W-1:0] kind;
	} entry_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic clear;   // drop all entries
		logic insert;  // place the broadcast entry
		logic shift;   // move every entry one cell toward the head
	} cell_ctl_t;

	typedef struct packed {
		entry_t            ent;
		logic [STAT_W-1:0] status;
		logic              last;
	} beat_t;

	function automatic logic [CLASS_W-1:0] class_of_kind(input logic [KIND_W-1:0] kind);
		logic [CLASS_W-1:0] cls;
		case (kind)
			KIND_USABLE:  cls = CLASS_RAM;
			KIND_RESERVE: cls = CLASS_RESERVED;
			KIND_ACPI_RC: cls = CLASS_ACPI;
			KIND_ACPI_NV: cls = CLASS_ACPI;
			default:      cls = CLASS_DEFECT;
		endcase
		return cls;
	endfunction

endpackage

@@ rtl/mmcs_cell.sv @@
`timescale 1ns / 1ps
// One slot of the insertion chain: holds a region and its valid bit.
// Depends on mmcs_pkg; talks only to its two neighbors and the broadcast.
module mmcs_cell import mmcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    new_ent,
	input  logic      prev_ins,
	input  entry_t    prev_ent,
	input  logic      prev_valid,
	input  entry_t    next_ent,
	input  logic      next_valid,
	output logic      ins,
	output entry_t    ent,
	output logic      valid
);

	entry_t ent_q;
	logic   valid_q;

	// at or behind the insert point: empty, or starts strictly later (equal starts stay ahead)
	assign ins   = !valid_q || (ent_q.start > new_ent.start);
	assign ent   = ent_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.insert && ins) begin
			valid_q <= prev_ins ? prev_valid : 1'b1;
		end else if (ctl.shift) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert && ins) begin
			ent_q <= prev_ins ? prev_ent : new_ent;
		end else if (ctl.shift) begin
			ent_q <= next_ent;
		end
	end

endmodule

@@ rtl/mmcs_out.sv @@
`timescale 1ns / 1ps
// Output register of the sorter: forms the end address and holds one beat.
// Depends on mmcs_pkg.
module mmcs_out import mmcs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  beat_t                 beat,
	output logic                  free,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [63:0] start, [127:64] end, [191:128] len
	output logic [OUT_USER_W-1:0] m_axis_tuser,   // [1:0] class, [4:2] sub-kind, [6:5] status
	output logic                  m_axis_tlast    // last result of the run
);

	logic                valid_q;
	logic [ADDR_W-1:0]   start_q;
	logic [ADDR_W-1:0]   end_q;
	logic [ADDR_W-1:0]   len_q;
	logic [CLASS_W-1:0]  class_q;
	logic [KIND_W-1:0]   kind_q;
	logic [STAT_W-1:0]   status_q;
	logic                last_q;

	assign free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			start_q  <= beat.ent.start;
			len_q    <= beat.ent.len;
			kind_q   <= beat.ent.kind;
			class_q  <= class_of_kind(beat.ent.kind);
			status_q <= beat.status;
			last_q   <= beat.last;
			// error beats carry all-zero payload
			if (beat.status == STAT_OK) begin
				end_q <= beat.ent.start + beat.ent.len - ADDR_W'(1);
			end else begin
				end_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {len_q, end_q, start_q};
	assign m_axis_tuser  = {status_q, kind_q, class_q};
	assign m_axis_tlast  = last_q;

endmodule

@@ rtl/memory_map_classify_sort.sv @@
`timescale 1ns / 1ps
// Top level of the memory-map classifier and stable sorter.
// Depends on mmcs_pkg, mmcs_cell and mmcs_out.

// The block takes one map entry per cycle while a map loads: each entry drops
// straight into its place in a chain of MAX_REGIONS cells, which keeps the regions
// ordered by start address with equal starts in arrival order. The beat with
// tlast closes the map; s_axis_tready then stays low while the chain drains
// toward its head, one region per cycle when the sink takes every beat.
// An unknown source type or more than MAX_REGIONS entries turns the whole
// run into a single error beat with zero payload.
module memory_map_classify_sort import mmcs_pkg::*; #(
	parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [63:0] start, [127:64] len, [159:128] type
	input  logic                  s_axis_tlast,   // last entry of the map
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [63:0] start, [127:64] end, [191:128] len
	output logic [OUT_USER_W-1:0] m_axis_tuser,   // [1:0] class, [4:2] sub-kind, [6:5] status
	output logic                  m_axis_tlast    // last result of the run
);

	localparam int CNT_W = $clog2(MAX_REGIONS + 1);

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic             bad_q;
	logic             ovf_q;

	logic [TYPE_W-1:0] src_type;
	logic              type_ok;
	logic              room;
	logic              accept;
	logic              store;
	logic              err_run;
	logic              out_free;
	logic              out_load;
	beat_t             out_beat;
	entry_t            new_ent;
	cell_ctl_t         ctl;

	entry_t ent_a   [MAX_REGIONS];
	logic   valid_a [MAX_REGIONS];
	logic   ins_a   [MAX_REGIONS];

	assign src_type      = s_axis_tdata[159:128];
	assign s_axis_tready = (state_q == ST_LOAD);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign room          = (count_q < CNT_W'(MAX_REGIONS));
	assign store         = accept && type_ok && room;
	assign err_run       = bad_q || ovf_q;

	always_comb begin
		type_ok       = (src_type inside {[TYPE_FIRST:TYPE_LAST]});
		new_ent.start = s_axis_tdata[63:0];
		new_ent.len   = s_axis_tdata[127:64];
		new_ent.kind  = src_type[KIND_W-1:0] - KIND_W'(1);
	end

	// drain: emit error beat, or the head cell while the chain still holds regions
	always_comb begin
		out_load  = (state_q == ST_DRAIN) && out_free && (err_run || valid_a[0]);
		ctl.clear = (state_q == ST_DRAIN) && out_free && err_run;
		ctl.insert = store;
		ctl.shift  = out_load && !err_run;
		if (err_run) begin
			out_beat.ent    = '0;
			out_beat.status = bad_q ? STAT_BAD_TYPE : STAT_OVERFLOW;
			out_beat.last   = 1'b1;
		end else begin
			out_beat.ent    = ent_a[0];
			out_beat.status = STAT_OK;
			out_beat.last   = !valid_a[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			bad_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (!type_ok) begin
							bad_q <= 1'b1;
						end else if (!room) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (s_axis_tlast) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					// run ends on the error beat, on the last region, or on an empty chain
					if (out_free && (err_run || !valid_a[0] || !valid_a[1])) begin
						state_q <= ST_LOAD;
						count_q <= '0;
						bad_q   <= 1'b0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
		logic   prev_ins;
		entry_t prev_ent;
		logic   prev_valid;
		entry_t next_ent;
		logic   next_valid;

		if (i == 0) begin : g_head
			assign prev_ins   = 1'b0;
			assign prev_ent   = new_ent;
			assign prev_valid = 1'b0;
		end else begin : g_body
			assign prev_ins   = ins_a[i-1];
			assign prev_ent   = ent_a[i-1];
			assign prev_valid = valid_a[i-1];
		end

		if (i == MAX_REGIONS - 1) begin : g_tail
			assign next_ent   = '0;
			assign next_valid = 1'b0;
		end else begin : g_link
			assign next_ent   = ent_a[i+1];
			assign next_valid = valid_a[i+1];
		end

		mmcs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_ent    (new_ent),
			.prev_ins   (prev_ins),
			.prev_ent   (prev_ent),
			.prev_valid (prev_valid),
			.next_ent   (next_ent),
			.next_valid (next_valid),
			.ins        (ins_a[i]),
			.ent        (ent_a[i]),
			.valid      (valid_a[i])
		);
	end

	mmcs_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (out_load),
		.beat          (out_beat),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
